[rtl/ibp_pkg.sv]
// ----------------------------------------------------------------------------
// Integer byte packer package
// Shared constants, codes, types and the value extension function.
// ----------------------------------------------------------------------------
package ibp_pkg;

	// Width of the value word and the number of bits that really count.
	localparam int WORD_BITS  = 64;
	localparam int VALUE_BITS = 64;
	localparam int BYTE_BITS  = 8;
	localparam int WORD_BYTES = WORD_BITS / BYTE_BITS;
	localparam int BER_BITS   = 7;
	localparam int BER_GROUPS = (WORD_BITS - 1 + BER_BITS - 1) / BER_BITS;

	// Operation codes.
	localparam logic [1:0] OP_UTF8  = 2'd0;
	localparam logic [1:0] OP_FIXED = 2'd1;
	localparam logic [1:0] OP_BER   = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_UTF8 = 2'd1;
	localparam logic [1:0] ERR_BER  = 2'd2;

	// How the serializer takes bytes out of its shift register.
	typedef enum logic [1:0] {
		MODE_MSB8,
		MODE_LSB8,
		MODE_BER
	} ibp_mode_t;

	// Load command from the decoder to the serializer.
	typedef struct packed {
		ibp_mode_t             mode;
		logic [WORD_BITS-1:0] data;
		logic [3:0]           count;
		logic [2:0]           skip;
		logic [1:0]           err;
	} ibp_load_t;

	// Sign-extend the value from bit VALUE_BITS-1.
	function automatic logic [WORD_BITS-1:0] ext_value(input logic [WORD_BITS-1:0] raw);
		logic [WORD_BITS-1:0] mask;
		logic [WORD_BITS-1:0] r;
		mask = {WORD_BITS{1'b1}} >> (WORD_BITS - VALUE_BITS);
		r = raw & mask;
		if (raw[VALUE_BITS-1]) begin
			r = r | ~mask;
		end
		return r;
	endfunction

endpackage

[rtl/ibp_in_if.sv]
// ----------------------------------------------------------------------------
// Integer byte packer input channel
// Valid/ready channel that carries one packing request per beat.
// ----------------------------------------------------------------------------
interface ibp_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic signed [63:0] value;
	logic [3:0]        byte_count;
	logic              big_endian;

	modport source (output valid, output operation, output value, output byte_count,
		output big_endian, input ready);
	modport sink (input valid, input operation, input value, input byte_count,
		input big_endian, output ready);
endinterface

[rtl/ibp_out_if.sv]
// ----------------------------------------------------------------------------
// Integer byte packer output channel
// Valid/ready channel that carries one packed byte per beat.
// ----------------------------------------------------------------------------
interface ibp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [1:0] error_code;

	modport source (output valid, output out_byte, output last, output error_code,
		input ready);
	modport sink (input valid, input out_byte, input last, input error_code,
		output ready);
endinterface

[rtl/ibp_serializer.sv]
// ----------------------------------------------------------------------------
// Integer byte packer serializer
// Shift register that drops leading digits and then sends one byte per beat.
// ----------------------------------------------------------------------------
module ibp_serializer
	import ibp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  ibp_load_t    cmd,
	output logic         idle,
	ibp_out_if.source    result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t               state_q;
	ibp_mode_t            mode_q;
	logic [WORD_BITS-1:0] sr_q;
	logic [3:0]           cnt_q;
	logic [2:0]           skip_q;
	logic [1:0]           err_q;

	logic [WORD_BITS-1:0] sr_next;
	logic [7:0]           byte_now;
	logic                 skip_go;
	logic                 is_last;

	// Byte at the head of the shift register and the shifted register.
	always_comb begin
		case (mode_q)
			MODE_LSB8: begin
				byte_now = sr_q[BYTE_BITS-1:0];
				sr_next  = sr_q >> BYTE_BITS;
			end
			MODE_BER: begin
				byte_now = {(cnt_q > 4'd1), sr_q[WORD_BITS-1 -: BER_BITS]};
				sr_next  = sr_q << BER_BITS;
			end
			default: begin
				byte_now = sr_q[WORD_BITS-1 -: BYTE_BITS];
				sr_next  = sr_q << BYTE_BITS;
			end
		endcase
	end

	// A BER group is dropped while it is zero and not the final one.
	always_comb begin
		if (mode_q == MODE_BER) begin
			skip_go = (cnt_q > 4'd1) && (sr_q[WORD_BITS-1 -: BER_BITS] == '0);
		end else begin
			skip_go = (skip_q != 3'd0);
		end
	end

	assign is_last = (cnt_q == 4'd1);

	// Sequencer: load, drop leading digits, then one byte per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_MSB8;
			sr_q    <= '0;
			cnt_q   <= '0;
			skip_q  <= '0;
			err_q   <= ERR_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						mode_q  <= cmd.mode;
						sr_q    <= cmd.data;
						cnt_q   <= cmd.count;
						skip_q  <= cmd.skip;
						err_q   <= cmd.err;
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (skip_go) begin
						sr_q <= sr_next;
						if (mode_q == MODE_BER) begin
							cnt_q <= cnt_q - 4'd1;
						end else begin
							skip_q <= skip_q - 3'd1;
						end
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (result.ready) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							sr_q  <= sr_next;
							cnt_q <= cnt_q - 4'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle              = (state_q == ST_IDLE);
	assign result.valid      = (state_q == ST_EMIT);
	assign result.out_byte   = byte_now;
	assign result.last       = is_last;
	assign result.error_code = err_q;

endmodule

[rtl/integer_byte_packer.sv]
// ----------------------------------------------------------------------------
// Integer byte packer
// Packs a signed integer as UTF-8, fixed-width bytes or a BER varint.
// ----------------------------------------------------------------------------
//  channel  direction  payload                                       beat
//  item     in         operation, value, byte_count, big_endian      one request
//  result   out        out_byte, last, error_code                    one byte
//
//  One request is held at a time. After a request is loaded, the serializer
//  shift register drops any leading digits, one digit per cycle, and then
//  sends one byte per accepted result beat. Reset clears the sequencer to
//  idle. A stalled result beat holds until it is taken.
// ----------------------------------------------------------------------------
module integer_byte_packer
	import ibp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ibp_in_if.sink    item,
	ibp_out_if.source result
);

	logic [WORD_BITS-1:0] v;
	logic [31:0]          utf_word;
	logic [3:0]           utf_count;
	logic [3:0]           fix_count;
	ibp_load_t            cmd;
	logic                 idle;
	logic                 load;

	assign v = ext_value(item.value);

	// UTF-8 forms, left aligned in a 32-bit word.
	always_comb begin
		if (v[31:0] < 32'd128) begin
			utf_word  = {v[7:0], 24'd0};
			utf_count = 4'd1;
		end else if (v[31:0] < 32'd2048) begin
			utf_word  = {3'b110, v[10:6], 2'b10, v[5:0], 16'd0};
			utf_count = 4'd2;
		end else if (v[31:0] < 32'd65536) begin
			utf_word  = {4'b1110, v[15:12], 2'b10, v[11:6], 2'b10, v[5:0], 8'd0};
			utf_count = 4'd3;
		end else begin
			utf_word  = {5'b11110, v[20:18], 2'b10, v[17:12], 2'b10, v[11:6],
				2'b10, v[5:0]};
			utf_count = 4'd4;
		end
	end

	// Fixed width: zero acts as one byte, counts above eight saturate.
	always_comb begin
		if (item.byte_count == 4'd0) begin
			fix_count = 4'd1;
		end else if (item.byte_count > 4'(WORD_BYTES)) begin
			fix_count = 4'(WORD_BYTES);
		end else begin
			fix_count = item.byte_count;
		end
	end

	// Decode the request into a load command for the serializer.
	always_comb begin
		cmd.mode  = MODE_MSB8;
		cmd.data  = '0;
		cmd.count = 4'd1;
		cmd.skip  = 3'd0;
		cmd.err   = ERR_NONE;
		case (item.operation)
			OP_UTF8: begin
				if (v[WORD_BITS-1:32] != '0) begin
					cmd.err = ERR_UTF8;
				end else begin
					cmd.data  = {utf_word, 32'd0};
					cmd.count = utf_count;
				end
			end
			OP_FIXED: begin
				cmd.data  = v;
				cmd.count = fix_count;
				if (item.big_endian) begin
					cmd.skip = 3'(4'(WORD_BYTES) - fix_count);
				end else begin
					cmd.mode = MODE_LSB8;
				end
			end
			OP_BER: begin
				if (v[WORD_BITS-1]) begin
					cmd.err = ERR_BER;
				end else begin
					cmd.mode  = MODE_BER;
					cmd.data  = {v[WORD_BITS-2:0], 1'b0};
					cmd.count = 4'(BER_GROUPS);
				end
			end
			default: begin
				cmd.err = ERR_NONE;
			end
		endcase
	end

	assign item.ready = idle;
	assign load       = item.valid && idle;

	ibp_serializer u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.cmd    (cmd),
		.idle   (idle),
		.result (result)
	);

	// An error answers with a single zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.error_code != ERR_NONE)
		|-> result.last && (result.out_byte == 8'd0))
		else $error("error beat is not a single zero byte");

	// A request is never taken while a result beat is on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |-> !result.valid)
		else $error("request taken while a result is pending");

	// After a request is taken the block is busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second request taken back to back");

	// Once the final byte is taken the block is ready again.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.last |=> item.ready && !result.valid)
		else $error("block not idle after the final byte");

endmodule
